// ===== rtl/core/rrq_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin run queue package
// Shared field widths, operation and status codes, and the stored entry type.
// ----------------------------------------------------------------------------
package rrq_pkg;

    // Number of entries in the store. The count field and the capacity
    // register are five bits wide, enough to count a full store of this size.
    localparam int DEPTH = 16;

    localparam int ID_W  = 16;
    localparam int TU_W  = 16;
    localparam int RC_W  = 32;
    localparam int OCC_W = 5;

    // Operation codes carried in the func field.
    localparam logic [1:0] FN_ENQUEUE = 2'd0;
    localparam logic [1:0] FN_DEQUEUE = 2'd1;
    localparam logic [1:0] FN_TICK    = 2'd2;
    localparam logic [1:0] FN_ROTATE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [OCC_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [ID_W-1:0] process_id;
        logic [TU_W-1:0] time_units;
        logic [RC_W-1:0] cpu_time;
        logic [RC_W-1:0] total_time;
    } entry_t;

endpackage

// ===== rtl/core/rrq_if.sv =====
// ----------------------------------------------------------------------------
// Round-robin run queue channels
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface rrq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] process_id;
    logic [15:0] time_units;
    logic [31:0] cpu_time_in;
    logic [31:0] total_time_in;

    modport source (
        output valid,
        output func,
        output process_id,
        output time_units,
        output cpu_time_in,
        output total_time_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  process_id,
        input  time_units,
        input  cpu_time_in,
        input  total_time_in,
        output ready
    );
endinterface

interface rrq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        head_valid;
    logic [15:0] head_process_id;
    logic [15:0] head_time_units;
    logic [31:0] head_cpu_time;
    logic [31:0] head_total_time;
    logic [4:0]  count;

    modport source (
        output valid,
        output status,
        output head_valid,
        output head_process_id,
        output head_time_units,
        output head_cpu_time,
        output head_total_time,
        output count,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  head_valid,
        input  head_process_id,
        input  head_time_units,
        input  head_cpu_time,
        input  head_total_time,
        input  count,
        output ready
    );
endinterface

// ===== rtl/core/rrq_store.sv =====
// ----------------------------------------------------------------------------
// Run queue entry store
// Circular entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rrq_store #(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  rrq_pkg::entry_t    wr_data,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output rrq_pkg::entry_t    rd_data
);

    rrq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/rrq_age_unit.sv =====
// ----------------------------------------------------------------------------
// Run queue ageing unit
// Saturating increment of both residence counts, and optionally spends one
// time unit of the entry, stopping at zero.
// ----------------------------------------------------------------------------
module rrq_age_unit (
    input  rrq_pkg::entry_t entry_in,
    input  logic            spend,
    output rrq_pkg::entry_t entry_out
);

    always_comb
    begin
        entry_out.process_id = entry_in.process_id;
        entry_out.time_units = (spend && (entry_in.time_units != '0))
                             ? entry_in.time_units - 1'b1 : entry_in.time_units;
        entry_out.cpu_time   = (entry_in.cpu_time == '1)
                             ? entry_in.cpu_time : entry_in.cpu_time + 1'b1;
        entry_out.total_time = (entry_in.total_time == '1)
                             ? entry_in.total_time : entry_in.total_time + 1'b1;
    end

endmodule

// ===== rtl/core/round_robin_run_queue_core.sv =====
// Enqueue and any full or empty result are offered in the cycle after
// acceptance; dequeue and a rotate of a single entry pass through LOAD, a
// rotate of several entries through MOVE and LOAD, and a tick through WALK.
// One operation is in flight at a time; the next request is taken in the cycle
// after its result is accepted. A tick walks one entry per cycle (up to DEPTH).
// Reset empties the queue, sets capacity to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Round-robin run queue core
// Bounded circular ready queue with enqueue, dequeue, tick and rotate
// operations, sequenced over one entry memory and one shared ageing unit.
// ----------------------------------------------------------------------------
module round_robin_run_queue_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    rrq_in_if.sink     req,
    rrq_out_if.source  rsp
);

    localparam int DEPTH = rrq_pkg::DEPTH;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = rrq_pkg::OCC_W;
    // Wide enough for head plus occupancy without overflow.
    localparam int SUM_W = ((IDX_W > OCC_W) ? IDX_W : OCC_W) + 1;

    // Sequencer states. MOVE copies the old head to the tail during a
    // rotate; WALK ages one stored entry per cycle during a tick; LOAD takes
    // the registered read data into the result register.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_MOVE = 6'b000100,
        S_LOAD = 6'b001000,
        S_OUT  = 6'b010000,
        S_HOLD = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic [OCC_W-1:0]     cap_reg, cap_next;
    logic [OCC_W-1:0]     walk_cnt_reg, walk_cnt_next;
    logic [IDX_W-1:0]     walk_slot_reg, walk_slot_next;
    logic [1:0]           status_reg, status_next;
    logic                 hv_reg, hv_next;
    rrq_pkg::entry_t      result_reg, result_next;

    // Memory port controls.
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    rrq_pkg::entry_t      wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    rrq_pkg::entry_t      rd_data;

    // Shared ageing unit.
    logic                 spend;
    rrq_pkg::entry_t      aged;

    logic                 accept;
    logic [SUM_W-1:0]     tail_sum;
    logic [SUM_W-1:0]     tail_wrap;
    logic [IDX_W-1:0]     tail;
    logic [IDX_W-1:0]     head_inc;
    logic [IDX_W-1:0]     slot_inc;
    logic                 store_full;
    logic                 queue_full;
    rrq_pkg::entry_t      new_entry;

    rrq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rrq_age_unit u_age (
        .entry_in  (rd_data),
        .spend     (spend),
        .entry_out (aged)
    );

    assign accept = req.valid && req.ready;

    // The tail slot is head plus occupancy modulo DEPTH. Both terms are
    // below DEPTH or equal to it, so one conditional subtract suffices.
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(occ_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
    assign tail      = tail_wrap[IDX_W-1:0];

    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign slot_inc = (walk_slot_reg == IDX_W'(DEPTH - 1)) ? '0 : walk_slot_reg + 1'b1;

    // The capacity register may exceed the store, so the store size also
    // bounds the queue.
    assign store_full = 32'(occ_reg) >= 32'(DEPTH);
    assign queue_full = (occ_reg >= cap_reg) || store_full;

    assign new_entry.process_id = req.process_id;
    assign new_entry.time_units = req.time_units;
    assign new_entry.cpu_time   = req.cpu_time_in;
    assign new_entry.total_time = req.total_time_in;

    assign cap_next = cfg_we ? cfg_wdata : cap_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        walk_cnt_next  = walk_cnt_reg;
        walk_slot_next = walk_slot_reg;
        status_next    = status_reg;
        hv_next        = hv_reg;
        result_next    = result_reg;
        wr_en          = 1'b0;
        wr_addr        = tail;
        wr_data        = new_entry;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        spend          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == rrq_pkg::FN_ENQUEUE)
                    begin
                        hv_next     = 1'b0;
                        result_next = '0;
                        state_next  = S_OUT;
                        if (queue_full)
                        begin
                            status_next = rrq_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_next = rrq_pkg::ST_OK;
                            wr_en       = 1'b1;
                            occ_next    = occ_reg + 1'b1;
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        status_next = rrq_pkg::ST_EMPTY;
                        hv_next     = 1'b0;
                        result_next = '0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        // Every remaining operation starts by reading the head.
                        status_next = rrq_pkg::ST_OK;
                        hv_next     = 1'b1;
                        rd_en       = 1'b1;
                        case (req.func)
                            rrq_pkg::FN_DEQUEUE:
                            begin
                                head_next  = head_inc;
                                occ_next   = occ_reg - 1'b1;
                                state_next = S_LOAD;
                            end
                            rrq_pkg::FN_TICK:
                            begin
                                walk_cnt_next  = '0;
                                walk_slot_next = head_reg;
                                state_next     = S_WALK;
                            end
                            rrq_pkg::FN_ROTATE:
                            begin
                                state_next = (occ_reg > OCC_W'(1)) ? S_MOVE : S_LOAD;
                            end
                            default:
                            begin
                                state_next = S_LOAD;
                            end
                        endcase
                    end
                end
            end

            S_WALK:
            begin
                // Write back the aged entry and fetch the next one. Only the
                // head spends a time unit, and its aged copy is the result.
                spend   = (walk_cnt_reg == '0);
                wr_en   = 1'b1;
                wr_addr = walk_slot_reg;
                wr_data = aged;
                if (walk_cnt_reg == '0)
                begin
                    result_next = aged;
                end
                if ((walk_cnt_reg + OCC_W'(1)) == occ_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = slot_inc;
                    walk_slot_next = slot_inc;
                    walk_cnt_next  = walk_cnt_reg + 1'b1;
                end
            end

            S_MOVE:
            begin
                // With a full store the old head slot already is the new tail.
                wr_en      = !store_full;
                wr_data    = rd_data;
                head_next  = head_inc;
                rd_en      = 1'b1;
                rd_addr    = head_inc;
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                result_next = rd_data;
                state_next  = S_OUT;
            end

            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            cap_reg       <= rrq_pkg::CAP_RESET;
            walk_cnt_reg  <= '0;
            walk_slot_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            cap_reg       <= cap_next;
            walk_cnt_reg  <= walk_cnt_next;
            walk_slot_reg <= walk_slot_next;
        end
    end

    // Result payload registers hold still while the result is offered.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        hv_reg     <= hv_next;
        result_reg <= result_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = (state_reg == S_OUT);
    assign rsp.status          = status_reg;
    assign rsp.head_valid      = hv_reg;
    assign rsp.head_process_id = result_reg.process_id;
    assign rsp.head_time_units = result_reg.time_units;
    assign rsp.head_cpu_time   = result_reg.cpu_time;
    assign rsp.head_total_time = result_reg.total_time;
    assign rsp.count           = occ_reg;

    // A result on offer blocks new requests.
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request accepted while a result is pending");

    // Occupancy never exceeds the store.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= 32'(DEPTH))
        else $error("occupancy beyond store depth");

    // A successful enqueue adds exactly one entry.
    a_enqueue_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.func == rrq_pkg::FN_ENQUEUE) && !queue_full)
        |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("enqueue did not grow the queue");

    // The tick walk stays inside the occupied entries.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (walk_cnt_reg < occ_reg))
        else $error("tick walk ran past the queue");

endmodule

// ===== test/tb_round_robin_run_queue_core.sv =====
// ----------------------------------------------------------------------------
// Round-robin run queue core testbench
// Drives operation requests through the valid/ready request channel and
// checks every result against a cycle-free model of the circular ready queue.
// A directed opening covers the empty, full, saturation and single-entry
// cases. Randomised phases at several capacities follow, with random gaps on
// both channels and one long stall on the result side.
// ----------------------------------------------------------------------------
module tb_round_robin_run_queue_core;

    localparam int DEPTH       = rrq_pkg::DEPTH;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 40;
    // The result side stops accepting once, for HOLD_CYCLES, after HOLD_AFTER
    // results, so that the core backs up into the request channel.
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 400;

    // One request transaction as offered on the request channel.
    typedef struct packed {
        logic [1:0]      func;
        rrq_pkg::entry_t item;
    } op_request_t;

    // One result transaction as seen on the result channel.
    typedef struct packed {
        logic [1:0]                status;
        logic                      head_valid;
        rrq_pkg::entry_t           head;
        logic [rrq_pkg::OCC_W-1:0] count;
    } op_result_t;

    // ------------------------------------------------------------------------
    // Ready-queue model and result checker. The model is advanced when a
    // request transaction is accepted, and the outcome it predicts is queued
    // until the matching result transaction arrives.
    // ------------------------------------------------------------------------
    class run_queue_scoreboard;
        rrq_pkg::entry_t slots[DEPTH];
        int unsigned     head_slot;
        int unsigned     fill;
        int unsigned     cap_limit;
        op_result_t      awaited[$];
        int unsigned     errors;

        function new();
            head_slot = 0;
            fill      = 0;
            cap_limit = rrq_pkg::CAP_RESET;
            errors    = 0;
        endfunction

        function void set_capacity(logic [rrq_pkg::OCC_W-1:0] value);
            cap_limit = value;
        endfunction

        static function logic [rrq_pkg::RC_W-1:0] bump(logic [rrq_pkg::RC_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        // Apply one accepted operation to the model and queue its outcome.
        function void note_request(op_request_t rq);
            op_result_t  res;
            int unsigned s;
            res = '0;
            if (rq.func == rrq_pkg::FN_ENQUEUE)
            begin
                if (fill >= cap_limit || fill >= DEPTH)
                    res.status = rrq_pkg::ST_FULL;
                else
                begin
                    slots[(head_slot + fill) % DEPTH] = rq.item;
                    fill++;
                end
            end
            else if (fill == 0)
                res.status = rrq_pkg::ST_EMPTY;
            else if (rq.func == rrq_pkg::FN_DEQUEUE)
            begin
                res.head_valid = 1'b1;
                res.head       = slots[head_slot];
                head_slot      = (head_slot + 1) % DEPTH;
                fill--;
            end
            else if (rq.func == rrq_pkg::FN_TICK)
            begin
                for (int i = 0; i < fill; i++)
                begin
                    s = (head_slot + i) % DEPTH;
                    slots[s].cpu_time   = bump(slots[s].cpu_time);
                    slots[s].total_time = bump(slots[s].total_time);
                end
                if (slots[head_slot].time_units != '0)
                    slots[head_slot].time_units = slots[head_slot].time_units - 1'b1;
                res.head_valid = 1'b1;
                res.head       = slots[head_slot];
            end
            else
            begin
                if (fill > 1)
                begin
                    // With a full store the old head slot already is the tail.
                    if (fill < DEPTH)
                        slots[(head_slot + fill) % DEPTH] = slots[head_slot];
                    head_slot = (head_slot + 1) % DEPTH;
                end
                res.head_valid = 1'b1;
                res.head       = slots[head_slot];
            end
            res.count = fill[rrq_pkg::OCC_W-1:0];
            awaited.push_back(res);
        endfunction

        function void report(string what, op_result_t want, op_result_t got);
            errors++;
            if (errors <= 10)
            begin
                $display("mismatch (%s) at %0t", what, $realtime);
                $display("  expected st %0d hv %0d id %h tu %h cpu %h tot %h count %0d",
                         want.status, want.head_valid, want.head.process_id,
                         want.head.time_units, want.head.cpu_time,
                         want.head.total_time, want.count);
                $display("  actual   st %0d hv %0d id %h tu %h cpu %h tot %h count %0d",
                         got.status, got.head_valid, got.head.process_id,
                         got.head.time_units, got.head.cpu_time,
                         got.head.total_time, got.count);
            end
        endfunction

        function void check_result(op_result_t got);
            op_result_t want;
            if (awaited.size() == 0)
            begin
                report("result with nothing outstanding", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report("status", want, got);
            else if (got.head_valid !== want.head_valid)
                report("head_valid", want, got);
            else if (got.head.process_id !== want.head.process_id)
                report("head_process_id", want, got);
            else if (got.head.time_units !== want.head.time_units)
                report("head_time_units", want, got);
            else if (got.head.cpu_time !== want.head.cpu_time)
                report("head_cpu_time", want, got);
            else if (got.head.total_time !== want.head.total_time)
                report("head_total_time", want, got);
            else if (got.count !== want.count)
                report("count", want, got);
        endfunction

        function void finish_check();
            while (awaited.size() != 0)
                report("result never arrived", awaited.pop_front(), '0);
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [rrq_pkg::OCC_W-1:0] cfg_wdata;
    int unsigned               cycle_count = 0;
    bit                        pace_on = 1'b1;

    rrq_in_if  req_ch ();
    rrq_out_if rsp_ch ();

    run_queue_scoreboard sb = new();

    round_robin_run_queue_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #4 clk = ~clk;

    // Watchdog: a hung handshake ends the run rather than the simulator.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Gap before a transaction: zero in the unpaced stretches.
    function automatic int draw_gap();
        return pace_on ? $urandom_range(0, 10) : 0;
    endfunction

    // Field values leaning towards zero, the top of the range and small
    // numbers, so that exhaustion and saturation are reached often.
    function automatic logic [31:0] skewed_value(int unsigned bits);
        logic [31:0] top;
        logic [31:0] v;
        top = (bits == 32) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = top - $urandom_range(0, 2);
            2:       v = $urandom_range(1, 3);
            default: v = $urandom & top;
        endcase
        return v;
    endfunction

    function automatic rrq_pkg::entry_t random_entry();
        rrq_pkg::entry_t e;
        e.process_id = 16'(skewed_value(rrq_pkg::ID_W));
        e.time_units = 16'(skewed_value(rrq_pkg::TU_W));
        e.cpu_time   = skewed_value(rrq_pkg::RC_W);
        e.total_time = skewed_value(rrq_pkg::RC_W);
        return e;
    endfunction

    // Offer one request transaction and wait for it to be accepted. Valid is
    // left high afterwards so that back-to-back transactions keep it high.
    task automatic send_op(input op_request_t rq);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.func          <= rq.func;
        req_ch.process_id    <= rq.item.process_id;
        req_ch.time_units    <= rq.item.time_units;
        req_ch.cpu_time_in   <= rq.item.cpu_time;
        req_ch.total_time_in <= rq.item.total_time;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(rq);
    endtask

    task automatic issue(input logic [1:0] func, input logic [15:0] pid,
                         input logic [15:0] tu, input logic [31:0] cpu,
                         input logic [31:0] tot);
        op_request_t rq;
        rq.func            = func;
        rq.item.process_id = pid;
        rq.item.time_units = tu;
        rq.item.cpu_time   = cpu;
        rq.item.total_time = tot;
        send_op(rq);
    endtask

    // Stop offering, let every outstanding result come back and let the core
    // settle before the capacity register is touched.
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [rrq_pkg::OCC_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_capacity(value);
    endtask

    // Randomised operations in blocks of forty. Each block draws its own
    // enqueue bias, so the queue swings between filling up and running dry,
    // and its own pacing, so that unpaced stretches occur as well.
    task automatic run_random(input int n_items);
        op_request_t rq;
        int          enq_bias;
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 40 == 0)
            begin
                enq_bias = $urandom_range(10, 90);
                pace_on  = ($urandom_range(0, 3) != 0);
            end
            rq.item = random_entry();
            if ($urandom_range(0, 99) < enq_bias)
                rq.func = rrq_pkg::FN_ENQUEUE;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       rq.func = rrq_pkg::FN_DEQUEUE;
                    1:       rq.func = rrq_pkg::FN_TICK;
                    default: rq.func = rrq_pkg::FN_ROTATE;
                endcase
            end
            send_op(rq);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: draws a gap before each transaction, holds ready high
    // until a result is offered and hands it to the checker. Once in the run
    // it stalls for a long stretch while requests keep being offered.
    // ------------------------------------------------------------------------
    initial
    begin
        op_result_t got;
        int         gap;
        int         taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (taken == HOLD_AFTER)
                gap = HOLD_CYCLES;
            @(negedge clk);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            got.status          = rsp_ch.status;
            got.head_valid      = rsp_ch.head_valid;
            got.head.process_id = rsp_ch.head_process_id;
            got.head.time_units = rsp_ch.head_time_units;
            got.head.cpu_time   = rsp_ch.head_cpu_time;
            got.head.total_time = rsp_ch.head_total_time;
            got.count           = rsp_ch.count;
            sb.check_result(got);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Request side and run control.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.func          <= rrq_pkg::FN_ENQUEUE;
        req_ch.process_id    <= '0;
        req_ch.time_units    <= '0;
        req_ch.cpu_time_in   <= '0;
        req_ch.total_time_in <= '0;
        rsp_ch.ready         <= 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Every non-enqueue operation on an empty queue reports empty.
        issue(rrq_pkg::FN_DEQUEUE, 16'h1234, 16'h5678, 32'h1, 32'h2);
        issue(rrq_pkg::FN_TICK,    '1, '1, '1, '1);
        issue(rrq_pkg::FN_ROTATE,  '0, '0, '0, '0);
        // A single entry with no time left and counters at the ceiling: the
        // ticks must hold time at zero and saturate both counters, and a
        // rotate of one entry must leave it where it is.
        issue(rrq_pkg::FN_ENQUEUE, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        issue(rrq_pkg::FN_TICK,    '0, '0, '0, '0);
        issue(rrq_pkg::FN_ROTATE,  '0, '0, '0, '0);
        issue(rrq_pkg::FN_TICK,    '0, '0, '0, '0);
        issue(rrq_pkg::FN_DEQUEUE, '0, '0, '0, '0);
        // Two entries: rotate really moves the head, tick ages both.
        issue(rrq_pkg::FN_ENQUEUE, 16'h0000, 16'hFFFF, 32'h0, 32'h0);
        issue(rrq_pkg::FN_ENQUEUE, 16'h0001, 16'h0001, 32'h8000_0000, 32'h7FFF_FFFF);
        issue(rrq_pkg::FN_TICK,    '0, '0, '0, '0);
        issue(rrq_pkg::FN_ROTATE,  '0, '0, '0, '0);
        issue(rrq_pkg::FN_TICK,    '0, '0, '0, '0);
        issue(rrq_pkg::FN_DEQUEUE, '0, '0, '0, '0);
        issue(rrq_pkg::FN_DEQUEUE, '0, '0, '0, '0);
        drain();

        // With a capacity of zero every enqueue is refused.
        write_capacity(5'd0);
        issue(rrq_pkg::FN_ENQUEUE, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        // A capacity of one: the second enqueue is refused.
        write_capacity(5'd1);
        issue(rrq_pkg::FN_ENQUEUE, 16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        issue(rrq_pkg::FN_ENQUEUE, 16'h0F0F, 16'hF0F0, 32'h0, 32'h0);
        issue(rrq_pkg::FN_ROTATE,  '0, '0, '0, '0);
        issue(rrq_pkg::FN_DEQUEUE, '0, '0, '0, '0);
        drain();

        // Random phases. A capacity above the store size leaves the store
        // itself as the limit; the queue keeps its contents across changes.
        write_capacity(5'd16);
        run_random(350);
        drain();
        write_capacity(5'd31);
        run_random(300);
        drain();
        write_capacity(5'd1);
        run_random(120);
        drain();
        write_capacity(5'd2);
        run_random(120);
        drain();
        write_capacity(5'($urandom_range(3, 15)));
        run_random(300);
        drain();
        write_capacity(5'd0);
        run_random(40);
        drain();
        write_capacity(rrq_pkg::CAP_RESET);
        run_random(120);
        drain();

        sb.finish_check();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
